/* rtl/clt_pkg.sv */
// Command line tokenizer package: character codes, register indexes,
// the mode encoding and the state and result structs. No dependencies.
package clt_pkg;

  localparam int MAX_ARGS = 16;
  localparam int ARGS_W   = $clog2(MAX_ARGS + 1);
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_EOL = 8'h00;

  localparam logic [7:0] ESCAPE_RESET    = 8'd92;
  localparam logic [7:0] SEPARATOR_RESET = 8'd59;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_SQUOTE,
    MODE_DQUOTE,
    MODE_ESCAPE,
    MODE_ERROR
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic              token_started;
    logic [ARGS_W-1:0] args_done;
  } state_t;

  typedef struct packed {
    logic               char_valid;
    logic [7:0]         out_char;
    logic               arg_end;
    logic               command_end;
    logic               line_end;
    logic               syntax_error;
    logic [COUNT_W-1:0] arg_count;
  } result_t;

endpackage

/* rtl/clt_cfg.sv */
// Configuration registers of the tokenizer: escape and separator codes.
// Depends on clt_pkg.
module clt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [clt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                    wr_data,
  output logic [7:0]                    escape_char,
  output logic [7:0]                    separator_char
);
  import clt_pkg::*;

  logic [7:0] escape_r, escape_nxt;
  logic [7:0] separator_r, separator_nxt;

  always_comb begin
    escape_nxt    = escape_r;
    separator_nxt = separator_r;
    if (wr_en) begin
      case (wr_index)
        REG_ESCAPE:    escape_nxt    = wr_data;
        REG_SEPARATOR: separator_nxt = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r    <= ESCAPE_RESET;
      separator_r <= SEPARATOR_RESET;
    end else begin
      escape_r    <= escape_nxt;
      separator_r <= separator_nxt;
    end
  end

  assign escape_char    = escape_r;
  assign separator_char = separator_r;

endmodule

/* rtl/clt_step.sv */
// Per-character decision logic: from the current state and one character,
// the next state and the result. Purely combinational. Depends on clt_pkg.
module clt_step (
  input  clt_pkg::state_t  cur,
  input  logic [7:0]       ch,
  input  logic [7:0]       escape_char,
  input  logic [7:0]       separator_char,
  output clt_pkg::state_t  nxt,
  output clt_pkg::result_t res
);
  import clt_pkg::*;

  logic is_white;
  logic is_print;
  logic is_eol;
  logic fail;
  logic start;

  assign is_white = ch inside {8'h20, [8'h09:8'h0D]};
  assign is_print = ch inside {[8'h20:8'h7E]};
  assign is_eol   = (ch == CH_EOL);

  always_comb begin
    nxt   = cur;
    res   = '0;
    fail  = 1'b0;
    start = 1'b0;

    case (cur.mode)
      MODE_ERROR: begin
        if (is_eol) begin
          res.line_end = 1'b1;
          nxt.mode     = MODE_NORMAL;
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (is_eol) begin
          fail = 1'b1;
        end else if ((cur.mode == MODE_SQUOTE && ch == CH_SQ) ||
                     (cur.mode == MODE_DQUOTE && ch == CH_DQ)) begin
          nxt.mode = MODE_NORMAL;
        end else begin
          res.char_valid = 1'b1;
          res.out_char   = ch;
        end
      end
      MODE_ESCAPE: begin
        if (is_print) begin
          res.char_valid = 1'b1;
          res.out_char   = ch;
          nxt.mode       = MODE_NORMAL;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        nxt.mode = MODE_NORMAL;
        if (is_eol) begin
          if (cur.token_started) begin
            res.arg_end   = 1'b1;
            nxt.args_done = cur.args_done + 1'b1;
          end
          res.line_end = 1'b1;
        end else if (!cur.token_started && is_white) begin
          // whitespace between arguments is dropped
        end else if (ch == CH_SQ || ch == CH_DQ || ch == escape_char) begin
          start = 1'b1;
        end else if (is_white || ch == separator_char) begin
          if (cur.token_started) begin
            res.arg_end       = 1'b1;
            nxt.args_done     = cur.args_done + 1'b1;
            nxt.token_started = 1'b0;
          end
          if (ch == separator_char) begin
            res.command_end = 1'b1;
          end
        end else if (is_print) begin
          start = 1'b1;
        end else begin
          fail = 1'b1;
        end

        if (start) begin
          // A new argument may not begin once the command is full.
          if (!cur.token_started && cur.args_done >= ARGS_W'(MAX_ARGS)) begin
            fail = 1'b1;
          end else begin
            nxt.token_started = 1'b1;
            if (ch == CH_SQ) begin
              nxt.mode = MODE_SQUOTE;
            end else if (ch == CH_DQ) begin
              nxt.mode = MODE_DQUOTE;
            end else if (ch == escape_char) begin
              nxt.mode = MODE_ESCAPE;
            end else begin
              res.char_valid = 1'b1;
              res.out_char   = ch;
            end
          end
        end
      end
    endcase

    res.arg_count = COUNT_W'(nxt.args_done);

    if (fail) begin
      res               = '0;
      res.syntax_error  = 1'b1;
      res.line_end      = is_eol;
      nxt.args_done     = '0;
      nxt.token_started = 1'b0;
      nxt.mode          = is_eol ? MODE_NORMAL : MODE_ERROR;
    end

    if (res.line_end || res.command_end) begin
      nxt.args_done     = '0;
      nxt.token_started = 1'b0;
    end
  end

endmodule

/* rtl/command_line_tokenizer_core.sv */
// Top level of the command line tokenizer: input register, parser state,
// result register and configuration registers. Depends on clt_pkg,
// clt_cfg and clt_step.
//
// One character is taken per request and each gives exactly one result.
// A character is registered on acceptance, decoded by the mode logic from
// the input register and written to the result register; one character can
// be taken every cycle while results are being taken. The result
// register and the input register advance together whenever the result
// register is empty or being taken. While a result waits, one further
// character can still be registered, after which the input stalls until
// the result is taken. Configuration writes are registered in clt_cfg and are
// expected only while no character is in flight.
module command_line_tokenizer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_char_valid,
  output logic [7:0]                    out_out_char,
  output logic                          out_arg_end,
  output logic                          out_command_end,
  output logic                          out_line_end,
  output logic                          out_syntax_error,
  output logic [clt_pkg::COUNT_W-1:0]   out_arg_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import clt_pkg::*;

  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       out_valid_r;
  result_t    res_r;
  state_t     state_r;

  state_t     state_nxt;
  result_t    res_nxt;
  logic [7:0] escape_char;
  logic [7:0] separator_char;
  logic       advance;

  assign cfg_ready = 1'b1;

  clt_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (cfg_valid),
    .wr_index       (cfg_index),
    .wr_data        (cfg_data),
    .escape_char    (escape_char),
    .separator_char (separator_char)
  );

  clt_step u_step (
    .cur            (state_r),
    .ch             (ch_r),
    .escape_char    (escape_char),
    .separator_char (separator_char),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: MODE_NORMAL, token_started: 1'b0, args_done: '0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_ch;
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_valid   = res_r.char_valid;
  assign out_out_char     = res_r.out_char;
  assign out_arg_end      = res_r.arg_end;
  assign out_command_end  = res_r.command_end;
  assign out_line_end     = res_r.line_end;
  assign out_syntax_error = res_r.syntax_error;
  assign out_arg_count    = res_r.arg_count;

endmodule

/* rtl/clt_checker.sv */
// Port-level checks for the command line tokenizer and the bind that
// attaches them to command_line_tokenizer_core. Depends on clt_pkg.
module clt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    in_ch,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_char_valid,
  input logic [7:0]                    out_out_char,
  input logic                          out_arg_end,
  input logic                          out_command_end,
  input logic                          out_line_end,
  input logic                          out_syntax_error,
  input logic [clt_pkg::COUNT_W-1:0]   out_arg_count
);
  import clt_pkg::*;

  // A waiting request keeps its character until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_ch))
    else $error("request changed while waiting");

  // A stalled result keeps its character, character flag, count and error flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_char) &&
      $stable(out_char_valid) && $stable(out_arg_count) && $stable(out_syntax_error))
    else $error("result changed while stalled");

  // An error result carries no character and a cleared count.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_syntax_error |-> !out_char_valid && !out_arg_end &&
      !out_command_end && out_arg_count == '0 && out_out_char == 8'h00)
    else $error("error result carries data");

  // A character is never delivered together with an end flag.
  a_char_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> !out_arg_end && !out_command_end && !out_line_end)
    else $error("character delivered with an end flag");

  // Only a separator ends a command, so it never coincides with a line end.
  a_cmd_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_end |-> !out_line_end)
    else $error("command end and line end together");

endmodule

bind command_line_tokenizer_core clt_checker u_clt_checker (.*);
